// ===== rtl/kwp_frame_receive_parser_macros.svh =====
// assertion macros for the frame receive parser checker
// expects clk and rst_n in the scope where the macros are used
`ifndef KWP_FRAME_RECEIVE_PARSER_MACROS_SVH
`define KWP_FRAME_RECEIVE_PARSER_MACROS_SVH

// same-cycle implication
`define KWP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwp checker: property failed");

// next-cycle implication
`define KWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwp checker: property failed");

`endif

// ===== rtl/kwp_pkg.sv =====
// shared types and constants of the frame receive parser
// no dependencies
`timescale 1ns / 1ps

package kwp_pkg;

  localparam logic [7:0] ADDR_MASK = 8'hC0;
  localparam logic [7:0] LEN_MASK  = 8'h3F;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    PH_FORMAT,
    PH_TARGET,
    PH_SOURCE,
    PH_LENGTH,
    PH_SERVICE,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SUM_ERR,
    ST_RX_ERR
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_fault;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] service_code;
    logic [7:0] target_addr;
    logic [7:0] source_addr;
    logic [7:0] frame_len;
    status_t    status;
    logic       last;
  } res_t;

endpackage

// ===== rtl/kwp_in_if.sv =====
// receive byte channel: valid/ready plus received byte and fault flag
// no dependencies
`timescale 1ns / 1ps

interface kwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_fault;

  modport source (output valid, output rx_byte, output rx_fault, input ready);
  modport sink   (input valid, input rx_byte, input rx_fault, output ready);
  modport mon    (input valid, input rx_byte, input rx_fault, input ready);
endinterface

// ===== rtl/kwp_out_if.sv =====
// result channel: valid/ready plus data byte or frame end report fields
// no dependencies
`timescale 1ns / 1ps

interface kwp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] service_code;
  logic [7:0] target_addr;
  logic [7:0] source_addr;
  logic [7:0] frame_len;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, output kind, output payload_byte, output payload_index,
    output service_code, output target_addr, output source_addr,
    output frame_len, output status, output last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input payload_index,
    input service_code, input target_addr, input source_addr,
    input frame_len, input status, input last, output ready
  );
  modport mon (
    input valid, input kind, input payload_byte, input payload_index,
    input service_code, input target_addr, input source_addr,
    input frame_len, input status, input last, input ready
  );
endinterface

// ===== rtl/kwp_parser.sv =====
// frame parser: phase machine, header registers, running checksum
// depends on kwp_pkg
`timescale 1ns / 1ps

module kwp_parser
  import kwp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_beat_t beat,
  output logic     res_valid,
  output res_t     res
);

  phase_t     phase_r, phase_nxt;
  logic       has_len_r, has_len_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] source_r, source_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] service_r, service_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] count_r, count_nxt;

  logic [7:0] b;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;
  logic [7:0] data_total;
  logic       fmt_addr;
  logic       fmt_len;

  assign b          = beat.rx_byte;
  assign sum_add    = sum_r + b;
  assign cnt_inc    = count_r + 8'd1;
  assign data_total = length_r - 8'd1;
  assign fmt_addr   = (b & ADDR_MASK) != 8'd0;
  assign fmt_len    = (b & LEN_MASK) == 8'd0;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (beat.rx_fault) begin
        phase_nxt = PH_FORMAT;
      end else begin
        case (phase_r)
          PH_TARGET:  phase_nxt = PH_SOURCE;
          PH_SOURCE:  phase_nxt = has_len_r ? PH_LENGTH : PH_SERVICE;
          PH_LENGTH:  phase_nxt = PH_SERVICE;
          PH_SERVICE: phase_nxt = (length_r <= 8'd1) ? PH_CHECK : PH_DATA;
          PH_DATA:    phase_nxt = (cnt_inc >= data_total) ? PH_CHECK : PH_DATA;
          PH_CHECK:   phase_nxt = PH_FORMAT;
          default: begin
            if (fmt_addr) phase_nxt = PH_TARGET;
            else if (fmt_len) phase_nxt = PH_LENGTH;
            else phase_nxt = PH_SERVICE;
          end
        endcase
      end
    end
  end

  // header registers, checksum and result
  always_comb begin
    has_len_nxt       = has_len_r;
    target_nxt        = target_r;
    source_nxt        = source_r;
    length_nxt        = length_r;
    service_nxt       = service_r;
    sum_nxt           = sum_r;
    count_nxt         = count_r;
    res_valid         = 1'b0;
    res.kind          = KIND_REPORT;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.service_code  = service_r;
    res.target_addr   = target_r;
    res.source_addr   = source_r;
    res.frame_len     = length_r;
    res.status        = ST_OK;
    res.last          = 1'b1;
    if (fire) begin
      if (beat.rx_fault || phase_r == PH_CHECK) begin
        res_valid = 1'b1;
        if (beat.rx_fault) res.status = ST_RX_ERR;
        else if (b != sum_r) res.status = ST_SUM_ERR;
        has_len_nxt = 1'b0;
        target_nxt  = 8'd0;
        source_nxt  = 8'd0;
        length_nxt  = 8'd0;
        service_nxt = 8'd0;
        sum_nxt     = 8'd0;
        count_nxt   = 8'd0;
      end else begin
        case (phase_r)
          PH_TARGET: begin
            target_nxt = b;
            sum_nxt    = sum_add;
          end
          PH_SOURCE: begin
            source_nxt = b;
            sum_nxt    = sum_add;
          end
          PH_LENGTH: begin
            length_nxt = b;
            sum_nxt    = sum_add;
          end
          PH_SERVICE: begin
            service_nxt = b;
            sum_nxt     = sum_add;
          end
          PH_DATA: begin
            res_valid         = 1'b1;
            res.kind          = KIND_DATA;
            res.payload_byte  = b;
            res.payload_index = count_r;
            res.last          = 1'b0;
            sum_nxt           = sum_add;
            count_nxt         = cnt_inc;
          end
          default: begin
            // format byte starts a new frame
            has_len_nxt = fmt_len;
            target_nxt  = 8'd0;
            source_nxt  = 8'd0;
            length_nxt  = b & LEN_MASK;
            service_nxt = 8'd0;
            sum_nxt     = b;
            count_nxt   = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FORMAT;
      has_len_r <= 1'b0;
      target_r  <= 8'd0;
      source_r  <= 8'd0;
      length_r  <= 8'd0;
      service_r <= 8'd0;
      sum_r     <= 8'd0;
      count_r   <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      has_len_r <= has_len_nxt;
      target_r  <= target_nxt;
      source_r  <= source_nxt;
      length_r  <= length_nxt;
      service_r <= service_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== rtl/kwp_out_buf.sv =====
// two-entry result buffer between parser and result channel
// depends on kwp_pkg
`timescale 1ns / 1ps

module kwp_out_buf
  import kwp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output res_t head
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) count_nxt = count_r + 2'd1;
    else if (!push && do_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/kwp_frame_receive_parser.sv =====
// frame receive parser, top level: one received byte per beat in,
// data bytes and frame end reports out; results are registered in the result buffer
// before out valid; throughput 1 byte per cycle while in ready is high, set by the
// parser update on every accepted beat and a 2-entry result buffer, in ready drops
// only while both buffer entries are held; synchronous active-low reset returns to
// waiting for a format byte, header and checksum registers zero, buffer empty
`timescale 1ns / 1ps

module kwp_frame_receive_parser
  import kwp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  kwp_in_if.sink   in_ch,
  kwp_out_if.source out_ch
);

  in_beat_t beat;
  logic     fire;
  logic     res_valid;
  res_t     res;
  logic     full;
  logic     head_valid;
  res_t     head;

  assign in_ch.ready   = !full;
  assign fire          = in_ch.valid && !full;
  assign beat.rx_byte  = in_ch.rx_byte;
  assign beat.rx_fault = in_ch.rx_fault;

  kwp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  kwp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire && res_valid),
    .push_data  (res),
    .full       (full),
    .pop        (out_ch.ready),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_ch.valid         = head_valid;
  assign out_ch.kind          = head.kind;
  assign out_ch.payload_byte  = head.payload_byte;
  assign out_ch.payload_index = head.payload_index;
  assign out_ch.service_code  = head.service_code;
  assign out_ch.target_addr   = head.target_addr;
  assign out_ch.source_addr   = head.source_addr;
  assign out_ch.frame_len     = head.frame_len;
  assign out_ch.status        = head.status;
  assign out_ch.last          = head.last;

endmodule

// ===== rtl/kwp_frame_checker.sv =====
// port-level checks of the frame receive parser, bound to the top level
// depends on kwp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "kwp_frame_receive_parser_macros.svh"

module kwp_frame_checker
  import kwp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_rx_fault,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic [1:0] out_status,
  input logic       out_last
);

  logic        stalled;
  logic [19:0] held_fields;
  logic        fault_beat;
  logic        report_zero;
  logic        data_clean;
  logic        status_known;

  assign stalled      = out_valid && !out_ready;
  assign held_fields  = {out_kind, out_payload_byte, out_payload_index, out_status, out_last};
  assign fault_beat   = in_valid && in_ready && in_rx_fault;
  assign report_zero  = (out_kind == KIND_REPORT) && (out_payload_byte == 8'd0)
                        && (out_payload_index == 8'd0);
  assign data_clean   = (out_kind == KIND_DATA) && (out_status == ST_OK);
  assign status_known = (out_status == ST_OK) || (out_status == ST_SUM_ERR)
                        || (out_status == ST_RX_ERR);

  `KWP_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(held_fields))
  `KWP_ASSERT_NOW(a_report_shape, out_valid && out_last, report_zero)
  `KWP_ASSERT_NOW(a_data_shape, out_valid && !out_last, data_clean)
  `KWP_ASSERT_NOW(a_status_code, out_valid, status_known)
  `KWP_ASSERT_NEXT(a_fault_reports, fault_beat, out_valid)

endmodule

bind kwp_frame_receive_parser kwp_frame_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_rx_fault       (in_ch.rx_fault),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_payload_byte  (out_ch.payload_byte),
  .out_payload_index (out_ch.payload_index),
  .out_status        (out_ch.status),
  .out_last          (out_ch.last)
);
